### design/gcd_pfi_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pfi_pkg
// Shared widths, types and state codes for the prime factor gcd block.
// ----------------------------------------------------------------------------
package gcd_pfi_pkg;

  localparam int OPW       = 16;
  localparam int MAXF      = 16;
  localparam int IDXW      = $clog2(MAXF);
  localparam int CNTW      = $clog2(MAXF + 1);
  localparam int SHW       = 5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FAC_START,
    ST_FAC_DIV,
    ST_FAC_WAIT,
    ST_ISECT_A,
    ST_ISECT_B,
    ST_ISECT_CMP,
    ST_MUL,
    ST_OUT
  } gcd_pfi_state_t;

  // request and reply between sequencer and divider
  typedef struct packed {
    logic           start;
    logic [OPW-1:0] dividend;
    logic [OPW-1:0] divisor;
  } gcd_pfi_div_req_t;

  typedef struct packed {
    logic           done;
    logic [OPW-1:0] quot;
    logic           zero_rem;
  } gcd_pfi_div_rsp_t;

endpackage

### design/gcd_by_prime_factor_intersection.sv
// ----------------------------------------------------------------------------
// gcd_by_prime_factor_intersection
// Gcd of two nonzero operands from the intersection of their prime factor lists.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)              | tuser/tlast
//  in_     | in  | value_a[15:0], value_b[31:16]          | none
//  out_    | out | common_divisor[15:0], count[20:16]     | none
//
// One word at a time. Each trial division runs a check, a start, 16
// divider steps and a result, so the run time of an operand grows with
// its largest prime factor; the intersection then compares both lists.
// Factor lists live in two RAMs with registered read.
// Reset returns to idle; in_tready is high only in idle. The result is held
// until out_tready takes it.
module gcd_by_prime_factor_intersection
  import gcd_pfi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value_a, value_b
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // common_divisor, shared_factor_count, pad
);

  gcd_pfi_state_t   state_r, state_nxt;
  gcd_pfi_div_req_t dreq;
  gcd_pfi_div_rsp_t drsp;

  logic [OPW-1:0]  vb_r;
  logic [OPW-1:0]  v_r, v_nxt;
  logic [OPW-1:0]  d_r, d_nxt;
  logic            side_r, side_nxt;
  logic [CNTW-1:0] cnta_r, cnta_nxt, cntb_r, cntb_nxt;
  logic [IDXW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [MAXF-1:0] clm_r, clm_nxt;
  logic [OPW-1:0]  prod_r, prod_nxt;
  logic [SHW-1:0]  sh_r, sh_nxt;
  logic [OPW-1:0]  fa_r, fa_nxt;
  logic [2*OPW-1:0] mul;

  logic            we_a, we_b;
  logic [IDXW-1:0] waddr, raddr_b;
  logic [OPW-1:0]  rdata_a, rdata_b;
  logic [CNTW-1:0] cur_cnt;

  gcd_pfi_ram #(.WIDTH(OPW), .DEPTH(MAXF)) u_ram_a (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(d_r),
    .raddr(i_r), .rdata(rdata_a)
  );
  gcd_pfi_ram #(.WIDTH(OPW), .DEPTH(MAXF)) u_ram_b (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(d_r),
    .raddr(raddr_b), .rdata(rdata_b)
  );
  gcd_pfi_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign cur_cnt = side_r ? cntb_r : cnta_r;
  assign waddr   = cur_cnt[IDXW-1:0];
  assign raddr_b = j_r;
  assign mul     = prod_r * fa_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_tvalid) state_nxt = ST_FAC_START;
      ST_FAC_START: begin
        if (v_r > OPW'(1)) state_nxt = ST_FAC_DIV;
        else if (side_r)   state_nxt = ST_ISECT_A;
      end
      ST_FAC_DIV:   state_nxt = ST_FAC_WAIT;
      ST_FAC_WAIT:  if (drsp.done) state_nxt = ST_FAC_START;
      ST_ISECT_A: begin
        if (cnta_r == '0 || cntb_r == '0) state_nxt = ST_OUT;
        else state_nxt = ST_ISECT_B;
      end
      ST_ISECT_B:   state_nxt = ST_ISECT_CMP;
      ST_ISECT_CMP: begin
        if (!clm_r[j_r] && rdata_b == fa_r) state_nxt = ST_MUL;
        else if ({1'b0, j_r} == CNTW'(cntb_r - 1'b1)) begin
          if ({1'b0, i_r} == CNTW'(cnta_r - 1'b1)) state_nxt = ST_OUT;
          else state_nxt = ST_ISECT_A;
        end else state_nxt = ST_ISECT_B;
      end
      ST_MUL: begin
        if ({1'b0, i_r} == CNTW'(cnta_r - 1'b1)) state_nxt = ST_OUT;
        else state_nxt = ST_ISECT_A;
      end
      ST_OUT:       if (out_tready) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    v_nxt    = v_r;
    d_nxt    = d_r;
    side_nxt = side_r;
    cnta_nxt = cnta_r;
    cntb_nxt = cntb_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    clm_nxt  = clm_r;
    prod_nxt = prod_r;
    sh_nxt   = sh_r;
    fa_nxt   = fa_r;
    we_a     = 1'b0;
    we_b     = 1'b0;
    dreq     = '{start: 1'b0, dividend: v_r, divisor: d_r};
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = (state_r == ST_OUT);
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          v_nxt    = in_tdata[OPW-1:0];
          d_nxt    = OPW'(2);
          side_nxt = 1'b0;
          cnta_nxt = '0;
          cntb_nxt = '0;
          prod_nxt = OPW'(1);
          sh_nxt   = '0;
          i_nxt    = '0;
          j_nxt    = '0;
          clm_nxt  = '0;
        end
      end
      ST_FAC_START: begin
        if (v_r <= OPW'(1) && !side_r) begin
          side_nxt = 1'b1;
          v_nxt    = vb_r;
          d_nxt    = OPW'(2);
        end
      end
      ST_FAC_DIV: dreq.start = 1'b1;
      ST_FAC_WAIT: begin
        if (drsp.done) begin
          if (drsp.zero_rem) begin
            v_nxt = drsp.quot;
            if (cur_cnt < CNTW'(MAXF)) begin
              we_a = !side_r;
              we_b = side_r;
              if (side_r) cntb_nxt = cntb_r + 1'b1;
              else        cnta_nxt = cnta_r + 1'b1;
            end
          end else begin
            d_nxt = d_r + 1'b1;
          end
        end
      end
      ST_ISECT_A: j_nxt = '0;
      ST_ISECT_B: fa_nxt = rdata_a;
      ST_ISECT_CMP: begin
        if (!clm_r[j_r] && rdata_b == fa_r) begin
          clm_nxt[j_r] = 1'b1;
          sh_nxt       = sh_r + 1'b1;
        end else if ({1'b0, j_r} == CNTW'(cntb_r - 1'b1)) begin
          i_nxt = i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_MUL: begin
        prod_nxt = mul[OPW-1:0];
        i_nxt    = i_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (state_r == ST_IDLE && in_tvalid) begin
      vb_r <= in_tdata[2*OPW-1:OPW];
    end
    v_r    <= v_nxt;
    d_r    <= d_nxt;
    side_r <= side_nxt;
    cnta_r <= cnta_nxt;
    cntb_r <= cntb_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    clm_r  <= clm_nxt;
    prod_r <= prod_nxt;
    sh_r   <= sh_nxt;
    fa_r   <= fa_nxt;
  end

  // result word
  assign out_tdata = {3'b000, sh_r, prod_r};

endmodule

### design/gcd_pfi_ram.sv
// ----------------------------------------------------------------------------
// gcd_pfi_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module gcd_pfi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/gcd_pfi_div.sv
// ----------------------------------------------------------------------------
// gcd_pfi_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gcd_pfi_div
  import gcd_pfi_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  gcd_pfi_div_req_t req,
  output gcd_pfi_div_rsp_t rsp
);

  localparam int BW = $clog2(OPW + 1);

  logic [OPW-1:0] rem_r, rem_nxt;
  logic [OPW-1:0] quo_r, quo_nxt;
  logic [OPW-1:0] dvs_r, dvs_nxt;
  logic [BW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [OPW:0]   trial;
  logic [OPW:0]   shifted;

  // one restoring step per cycle
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[OPW-1]};
    trial    = shifted - {1'b0, dvs_r};
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = BW'(OPW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[OPW]) begin
        rem_nxt = shifted[OPW-1:0];
        quo_nxt = {quo_r[OPW-2:0], 1'b0};
      end else begin
        rem_nxt = trial[OPW-1:0];
        quo_nxt = {quo_r[OPW-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == BW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quot     = quo_r;
  assign rsp.zero_rem = (rem_r == '0);

endmodule

### test/gcd_pfi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pfi_checker
// Watches both stream channels of the prime factor gcd block, predicts the
// result of every accepted input word and compares each output word against
// the oldest prediction.
// ----------------------------------------------------------------------------
module gcd_pfi_checker
  import gcd_pfi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // value_a, value_b
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // common_divisor, shared_factor_count, pad
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic [OPW-1:0] divisor;
    logic [SHW-1:0] count;
  } gcd_result_t;

  gcd_result_t gcd_queue[$];

  // ascending prime factors with multiplicity, capped at MAXF entries
  function automatic int factor_list(input logic [OPW-1:0] val,
                                     output logic [OPW-1:0] primes[MAXF]);
    int v;
    int d;
    int n;
    v = val;
    d = 2;
    n = 0;
    while (v > 1) begin
      if (v % d == 0) begin
        if (n < MAXF) begin
          primes[n] = d[OPW-1:0];
          n++;
        end
        v = v / d;
      end else begin
        d++;
      end
    end
    return n;
  endfunction

  // multiset intersection of both factor lists
  function automatic gcd_result_t predict_gcd(input logic [OPW-1:0] a,
                                              input logic [OPW-1:0] b);
    logic [OPW-1:0] pa[MAXF];
    logic [OPW-1:0] pb[MAXF];
    bit             taken[MAXF];
    int             na;
    int             nb;
    logic [31:0]    prod;
    int             shared;
    gcd_result_t    r;
    na = factor_list(a, pa);
    nb = factor_list(b, pb);
    prod = 1;
    shared = 0;
    foreach (taken[k]) taken[k] = 0;
    for (int i = 0; i < na; i++) begin
      for (int j = 0; j < nb; j++) begin
        if (!taken[j] && pb[j] == pa[i]) begin
          taken[j] = 1;
          prod = prod * pa[i];
          shared++;
          break;
        end
      end
    end
    r.divisor = prod[OPW-1:0];
    r.count = shared[SHW-1:0];
    return r;
  endfunction

  assign pending = gcd_queue.size();

  // predict on input words, compare on output words
  always @(posedge clk) begin
    gcd_result_t want;
    gcd_result_t got;
    if (!rst_n) begin
      mismatches <= 0;
    end else begin
      if (in_tvalid && in_tready)
        gcd_queue.push_back(predict_gcd(in_tdata[15:0], in_tdata[31:16]));
      if (out_tvalid && out_tready) begin
        got.divisor = out_tdata[15:0];
        got.count = out_tdata[20:16];
        if (gcd_queue.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected output word: divisor %0d count %0d",
                     got.divisor, got.count);
          mismatches <= mismatches + 1;
        end else begin
          want = gcd_queue.pop_front();
          if (want != got) begin
            if (mismatches < 10)
              $display("word mismatch: expected divisor %0d count %0d, got %0d %0d",
                       want.divisor, want.count, got.divisor, got.count);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

### test/tb_gcd_by_prime_factor_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gcd_by_prime_factor_intersection
// Drives operand pairs into the prime factor gcd block with random gaps and
// output stalls; a checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_gcd_by_prime_factor_intersection;
  import gcd_pfi_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // value_a, value_b
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // common_divisor, shared_factor_count, pad
  int          mismatches;
  int          pending;
  bit          steady;

  int small_primes[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};

  gcd_by_prime_factor_intersection uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  gcd_pfi_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .mismatches, .pending
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // mostly short gaps, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // random output stalls
  always @(negedge clk) begin
    if (!rst_n) out_tready = 1'b0;
    else out_tready = (gap_len() == 0);
  end

  // one operand pair, held until accepted
  task automatic send_pair(input logic [15:0] a, input logic [15:0] b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {b, a};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // product of random small primes kept within 16 bits
  function automatic int build_operand(input int base, input int tries);
    int v;
    int p;
    v = base;
    for (int i = 0; i < tries; i++) begin
      p = small_primes[$urandom_range(0, 11)];
      if (v * p < 65536) v = v * p;
    end
    return v;
  endfunction

  initial begin
    int g;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    steady = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // zero and one operands, extremes, deep powers, one large prime
    send_pair(16'd0, 16'd0);
    send_pair(16'd0, 16'd12);
    send_pair(16'd12, 16'd0);
    send_pair(16'd1, 16'd1);
    send_pair(16'd1, 16'd36);
    send_pair(16'd65535, 16'd65535);
    send_pair(16'd65535, 16'd0);
    send_pair(16'd32768, 16'd32768);
    send_pair(16'd32768, 16'd49152);
    send_pair(16'd59049, 16'd19683);
    send_pair(16'd2, 16'd3);
    send_pair(16'd360, 16'd756);
    send_pair(16'd65521, 16'd2);
    send_pair(16'd30030, 16'd510);
    send_pair(16'd1024, 16'd1000);

    // mostly structured pairs with a shared part, a little raw noise
    for (int n = 0; n < 100; n++) begin
      steady = (n >= 40 && n < 55);
      if ($urandom_range(0, 29) == 0) begin
        send_pair(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      end else begin
        g = build_operand(1, $urandom_range(0, 4));
        send_pair(16'(build_operand(g, $urandom_range(0, 6))),
                  16'(build_operand(g, $urandom_range(0, 6))));
      end
    end
    in_tvalid = 1'b0;
    steady = 0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // large primes take long to factor, so the limit is wide
  initial begin
    repeat (10) #400_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
design/gcd_pfi_pkg.sv
design/gcd_pfi_ram.sv
design/gcd_pfi_div.sv
design/gcd_by_prime_factor_intersection.sv
test/gcd_pfi_checker.sv
test/tb_gcd_by_prime_factor_intersection.sv
